### hw/rtl/csvp_pkg.sv
// Shared types and constants for the CSV row parser.
package csvp_pkg;

  // Characters with a meaning to the parser
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // Request kind
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOI  = 1'b1;

  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_UNQ      = 3'd1,
    MODE_QUOTED   = 3'd2,
    MODE_QSEEN    = 3'd3,
    MODE_AFTER_CR = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       kind;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       row_end;
  } out_req_t;

  // Decision for one input request
  typedef struct packed {
    mode_t    mode_nxt;
    logic     after_sep_nxt;
    logic     emit;
    out_req_t res;
  } step_t;

endpackage

### hw/rtl/csvp_decode.sv
// Per-byte decision logic of the CSV row parser: next mode and result.
module csvp_decode (
  input  csvp_pkg::mode_t   mode,
  input  logic              after_sep,
  input  csvp_pkg::in_req_t req,
  output csvp_pkg::step_t   step
);

  logic            eoi;
  logic            eol;
  logic            is_cr;
  logic            is_comma;
  logic            is_quote;
  logic            swallow;
  csvp_pkg::mode_t eff_mode;
  logic            eff_sep;

  assign eoi      = (req.kind == csvp_pkg::KIND_EOI);
  assign is_cr    = !eoi && (req.in_byte == csvp_pkg::CH_CR);
  assign eol      = eoi || (req.in_byte == csvp_pkg::CH_LF) || (req.in_byte == csvp_pkg::CH_CR);
  assign is_comma = (req.in_byte == csvp_pkg::CH_COMMA);
  assign is_quote = (req.in_byte == csvp_pkg::CH_QUOTE);
  // LF straight after CR belongs to the same line end
  assign swallow  = (mode == csvp_pkg::MODE_AFTER_CR) && !eoi &&
                    (req.in_byte == csvp_pkg::CH_LF);

  always_comb begin
    step               = '0;
    step.mode_nxt      = mode;
    step.after_sep_nxt = after_sep;
    eff_mode           = mode;
    eff_sep            = after_sep;

    if (mode == csvp_pkg::MODE_AFTER_CR) begin
      step.mode_nxt      = csvp_pkg::MODE_START;
      step.after_sep_nxt = 1'b0;
      eff_mode           = csvp_pkg::MODE_START;
      eff_sep            = 1'b0;
    end

    if (!swallow) begin
      case (eff_mode)
        csvp_pkg::MODE_UNQ: begin
          if (eol) begin
            step.mode_nxt      = is_cr ? csvp_pkg::MODE_AFTER_CR : csvp_pkg::MODE_START;
            step.after_sep_nxt = 1'b0;
            step.emit          = 1'b1;
            step.res.field_end = 1'b1;
            step.res.row_end   = 1'b1;
          end else if (is_comma) begin
            step.mode_nxt      = csvp_pkg::MODE_START;
            step.after_sep_nxt = 1'b1;
            step.emit          = 1'b1;
            step.res.field_end = 1'b1;
          end else begin
            step.emit           = 1'b1;
            step.res.out_byte   = req.in_byte;
            step.res.byte_valid = 1'b1;
          end
        end
        csvp_pkg::MODE_QUOTED: begin
          // line ends are data inside quotes; only end of input closes
          if (eoi) begin
            step.mode_nxt      = csvp_pkg::MODE_START;
            step.after_sep_nxt = 1'b0;
            step.emit          = 1'b1;
            step.res.field_end = 1'b1;
            step.res.row_end   = 1'b1;
          end else if (is_quote) begin
            step.mode_nxt = csvp_pkg::MODE_QSEEN;
          end else begin
            step.emit           = 1'b1;
            step.res.out_byte   = req.in_byte;
            step.res.byte_valid = 1'b1;
          end
        end
        csvp_pkg::MODE_QSEEN: begin
          if (eol) begin
            step.mode_nxt      = is_cr ? csvp_pkg::MODE_AFTER_CR : csvp_pkg::MODE_START;
            step.after_sep_nxt = 1'b0;
            step.emit          = 1'b1;
            step.res.field_end = 1'b1;
            step.res.row_end   = 1'b1;
          end else if (is_comma) begin
            step.mode_nxt      = csvp_pkg::MODE_START;
            step.after_sep_nxt = 1'b1;
            step.emit          = 1'b1;
            step.res.field_end = 1'b1;
          end else begin
            // doubled quote, or any other byte: keep it, stay quoted
            step.mode_nxt       = csvp_pkg::MODE_QUOTED;
            step.emit           = 1'b1;
            step.res.out_byte   = req.in_byte;
            step.res.byte_valid = 1'b1;
          end
        end
        default: begin
          // field start, also after CR and for unused codes
          if (eol) begin
            step.mode_nxt      = is_cr ? csvp_pkg::MODE_AFTER_CR : csvp_pkg::MODE_START;
            step.after_sep_nxt = 1'b0;
            step.emit          = 1'b1;
            step.res.field_end = eff_sep;
            step.res.row_end   = 1'b1;
          end else if (is_quote) begin
            step.mode_nxt      = csvp_pkg::MODE_QUOTED;
            step.after_sep_nxt = 1'b0;
          end else if (is_comma) begin
            step.mode_nxt      = csvp_pkg::MODE_START;
            step.after_sep_nxt = 1'b1;
            step.emit          = 1'b1;
            step.res.field_end = 1'b1;
          end else begin
            step.mode_nxt       = csvp_pkg::MODE_UNQ;
            step.after_sep_nxt  = 1'b0;
            step.emit           = 1'b1;
            step.res.out_byte   = req.in_byte;
            step.res.byte_valid = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

### hw/rtl/csv_row_parser.sv
// Top level of the streaming CSV row parser.
//
// Usage
//   Input channel (in_valid / in_stall / in_data): one request per cycle while
//   in_stall is low, each a CSV byte or, with kind set, an end-of-input mark.
//   Output channel (out_valid / out_stall / out_data): field bytes, field-end
//   and row-end marks. A request gives at most one result; opening and
//   escaping quotes and an LF after CR give none.
//   Timing: a result is registered in the output register as its request is
//   taken.
//   Throughput: one request per cycle while in_stall is low, set by the
//   combinational mode decision feeding the output register. A request is
//   taken even while a result is waiting, as long as that result leaves in the same cycle.
//   Stall: while the output register holds a result and out_stall is high,
//   in_stall is raised and the parse state holds.
//   Reset: synchronous, active low. Clears the parse mode to field start, the
//   separator flag and the output valid; no clearing pass is needed.
module csv_row_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  csvp_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output csvp_pkg::out_req_t out_data
);

  csvp_pkg::mode_t    mode_r;
  csvp_pkg::mode_t    mode_nxt;
  logic               after_sep_r;
  logic               after_sep_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  csvp_pkg::out_req_t out_data_r;
  csvp_pkg::out_req_t out_data_nxt;
  csvp_pkg::step_t    step;
  logic               accept;

  csvp_decode u_decode (
    .mode      (mode_r),
    .after_sep (after_sep_r),
    .req       (in_data),
    .step      (step)
  );

  // Hold off input only when the waiting result cannot leave this cycle
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    mode_nxt      = mode_r;
    after_sep_nxt = after_sep_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      mode_nxt      = step.mode_nxt;
      after_sep_nxt = step.after_sep_nxt;
      out_valid_nxt = step.emit;
      if (step.emit) begin
        out_data_nxt = step.res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= csvp_pkg::MODE_START;
      after_sep_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      after_sep_r <= after_sep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
